// ===== rtl/fvhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// fvhsv_pkg: shared types and constants of the flow-vector HSV color coder
// Holds the item structs, hue constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package fvhsv_pkg;
    localparam int FLOW_WIDTH_DEF = 16;
    localparam logic [15:0] MAX_FLOW_RESET = 16'd2560;
    localparam int HUE_W = 15;
    localparam int CORDIC_STEPS = 13;
    localparam logic [14:0] HUE_FULL = 15'd24576;
    localparam logic [14:0] HUE_HALF = 15'd12288;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } fvhsv_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic cordic_step;
        logic sqrt_step;
        logic prep_div;
        logic div_step;
        logic measure_done;
        logic finish;
    } fvhsv_cmd_t;

    typedef struct packed {
        logic is_color;
    } fvhsv_sts_t;

    function automatic logic [11:0] atan_lut(input logic [3:0] i);
        logic [11:0] r;
        begin
            case (i)
                4'd0: r = 12'd3072;
                4'd1: r = 12'd1813;
                4'd2: r = 12'd958;
                4'd3: r = 12'd486;
                4'd4: r = 12'd244;
                4'd5: r = 12'd122;
                4'd6: r = 12'd61;
                4'd7: r = 12'd31;
                4'd8: r = 12'd15;
                4'd9: r = 12'd8;
                4'd10: r = 12'd4;
                4'd11: r = 12'd2;
                4'd12: r = 12'd1;
                default: r = 12'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/flow_vector_to_hsv_color_unit.sv =====
// ----------------------------------------------------------------------------
// flow_vector_to_hsv_color_unit: optical flow vector to HSV color bytes
// One item at a time: the bit-pair square root runs beside the 13 CORDIC
// steps, then a setup state, then 36 restoring division steps for the two
// color fractions; a measure item ends in the setup state, and a color item
// waits for the output handshake. max_flow of zero selects the running
// maximum.
// ----------------------------------------------------------------------------
`default_nettype none
module flow_vector_to_hsv_color_unit
    import fvhsv_pkg::*;
#(
    parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic                  s_frame_start,
    input  wire logic [FLOW_WIDTH-1:0] s_flow_u,
    input  wire logic [FLOW_WIDTH-1:0] s_flow_v,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output fvhsv_out_t                 m_data
);
    logic [15:0] max_flow_reg;
    fvhsv_cmd_t  cmd;
    fvhsv_sts_t  sts;
    logic [5:0]  step;

    assign cfg_ready = 1'b1;

    // Hold the full-scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_flow_reg <= MAX_FLOW_RESET;
        end else if (cfg_valid) begin
            max_flow_reg <= cfg_data;
        end
    end

    fvhsv_ctrl #(.FLOW_WIDTH(FLOW_WIDTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd), .step(step)
    );

    fvhsv_dp #(.FLOW_WIDTH(FLOW_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .max_flow(max_flow_reg),
        .in_kind(s_kind), .in_fs(s_frame_start), .in_u(s_flow_u), .in_v(s_flow_v),
        .step(step), .cmd(cmd), .sts(sts), .result(m_data)
    );
endmodule
`default_nettype wire

// ===== rtl/fvhsv_dp.sv =====
// ----------------------------------------------------------------------------
// fvhsv_dp: datapath of the flow color coder
// Serial square root, CORDIC vectoring, serial division and byte mapping.
// ----------------------------------------------------------------------------
`default_nettype none
module fvhsv_dp
    import fvhsv_pkg::*;
#(
    parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [15:0]           max_flow,
    input  wire logic                  in_kind,
    input  wire logic                  in_fs,
    input  wire logic [FLOW_WIDTH-1:0] in_u,
    input  wire logic [FLOW_WIDTH-1:0] in_v,
    input  wire logic [5:0]            step,
    input  wire fvhsv_cmd_t            cmd,
    output fvhsv_sts_t                 sts,
    output fvhsv_out_t                 result
);
    localparam int SQ_W   = 2 * FLOW_WIDTH + 2;  // sum of squares
    localparam int MAG_W  = FLOW_WIDTH + 1;
    localparam int MAGX_W = (MAG_W > 16) ? MAG_W : 17;
    localparam int CX_W   = FLOW_WIDTH + 20;     // cordic x/y width
    localparam int NUM_W  = 36;                  // dividend width

    logic                   kind_reg;
    logic                   fs_reg;
    logic [SQ_W-1:0]        rem_reg, rem_next;
    logic [MAG_W-1:0]       root_reg, root_next;
    logic signed [CX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [HUE_W+1:0] z_reg, z_next;
    logic [15:0]            run_max_reg, run_max_next;
    logic [2:0]             sector_reg;
    logic [NUM_W-1:0]       num_mb_reg, num_xb_reg;
    logic [29:0]            den_reg;
    logic [7:0]             q_mb_reg, q_xb_reg;
    logic [NUM_W-1:0]       rmb_reg, rxb_reg;
    logic                   white_reg;
    logic [FLOW_WIDTH-1:0]  au, av;
    logic [SQ_W-1:0]        trial;
    logic signed [CX_W-1:0] xs, ys;
    logic [HUE_W+1:0]       hue_raw;
    logic [HUE_W-1:0]       hue;
    logic [11:0]            f;
    logic [12:0]            t;
    logic [15:0]            m_sel, a_sel, d_ma;
    logic [NUM_W-1:0]       rmb_sh, rxb_sh, den_sh;
    logic [15:0]            mag_sat;
    logic [MAGX_W-1:0]      root_x;
    logic                   mag_big;
    logic [15:0]            mag16;

    assign sts.is_color = kind_reg;
    assign au = in_u[FLOW_WIDTH-1] ? FLOW_WIDTH'(-in_u) : in_u;
    assign av = in_v[FLOW_WIDTH-1] ? FLOW_WIDTH'(-in_v) : in_v;

    // Bit-pair square root trial: (4*root + 1) at the current bit pair
    assign trial = SQ_W'({root_reg, 2'b01}) << (2 * (MAG_W - 1 - int'(step)));

    // CORDIC shifted operands (arithmetic shift floors)
    assign xs = x_reg >>> step[3:0];
    assign ys = y_reg >>> step[3:0];

    // Hue wrap and sector split
    assign hue_raw = (z_reg < 0) ? (HUE_W+2)'(z_reg + $signed({2'b0, HUE_FULL}))
                   : (z_reg >= $signed({2'b0, HUE_FULL}))
                     ? (HUE_W+2)'(z_reg - $signed({2'b0, HUE_FULL})) : z_reg;
    assign hue = hue_raw[HUE_W-1:0];
    assign f = hue[11:0];
    assign t = hue[12] ? (13'd4096 - {1'b0, f}) : {1'b0, f};

    // Saturate the root to 16 bits and clamp it to the active maximum
    assign root_x = MAGX_W'(root_reg);
    assign mag_big = |root_x[MAGX_W-1:16];
    assign mag16 = mag_big ? 16'hFFFF : root_x[15:0];
    assign m_sel = (max_flow != 16'd0) ? max_flow : run_max_reg;
    assign mag_sat = (mag16 > m_sel) ? m_sel : mag16;
    assign a_sel = mag_sat;
    assign d_ma = m_sel - a_sel;

    // Restoring division: remainder shifts, subtract denominator
    assign rmb_sh = {rmb_reg[NUM_W-2:0], num_mb_reg[NUM_W-1]};
    assign rxb_sh = {rxb_reg[NUM_W-2:0], num_xb_reg[NUM_W-1]};
    assign den_sh = NUM_W'(den_reg);

    always_comb begin
        rem_next = rem_reg;
        root_next = root_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        run_max_next = run_max_reg;
        if (cmd.load) begin
            rem_next = SQ_W'(au) * SQ_W'(au) + SQ_W'(av) * SQ_W'(av);
            root_next = '0;
            x_next = in_u[FLOW_WIDTH-1]
                ? CX_W'($signed({1'b0, au})) <<< 16
                : CX_W'($signed({1'b0, in_u})) <<< 16;
            y_next = in_u[FLOW_WIDTH-1]
                ? (-(CX_W'($signed(in_v)))) <<< 16
                : CX_W'($signed(in_v)) <<< 16;
            z_next = in_u[FLOW_WIDTH-1] ? $signed({2'b0, HUE_HALF}) : '0;
        end
        if (cmd.cordic_step) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + $signed({5'b0, atan_lut(step[3:0])});
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - $signed({5'b0, atan_lut(step[3:0])});
            end
        end
        if (cmd.sqrt_step) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end else begin
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.measure_done) begin
            if (fs_reg) begin
                run_max_next = mag16;
            end else if (mag16 > run_max_reg) begin
                run_max_next = mag16;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_max_reg <= '0;
        end else begin
            run_max_reg <= run_max_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load) begin
            kind_reg <= in_kind;
            fs_reg <= in_fs;
        end
        if (cmd.prep_div) begin
            sector_reg <= hue[14:12];
            white_reg <= (m_sel == 16'd0);
            num_mb_reg <= (NUM_W'(d_ma) * NUM_W'(255)) << 12;
            num_xb_reg <= NUM_W'({d_ma, 12'd0} + 28'(a_sel * t)) * NUM_W'(255);
            den_reg <= {m_sel, 12'd0} + 30'd0;
            rmb_reg <= '0;
            rxb_reg <= '0;
            q_mb_reg <= '0;
            q_xb_reg <= '0;
        end
        if (cmd.div_step) begin
            num_mb_reg <= num_mb_reg << 1;
            num_xb_reg <= num_xb_reg << 1;
            rmb_reg <= (rmb_sh >= den_sh) ? rmb_sh - den_sh : rmb_sh;
            rxb_reg <= (rxb_sh >= den_sh) ? rxb_sh - den_sh : rxb_sh;
            q_mb_reg <= {q_mb_reg[6:0], rmb_sh >= den_sh};
            q_xb_reg <= {q_xb_reg[6:0], rxb_sh >= den_sh};
        end
    end

    // Sector ordering of the three bytes
    always_comb begin
        case (sector_reg)
            3'd0: result = '{8'd255, q_xb_reg, q_mb_reg};
            3'd1: result = '{q_xb_reg, 8'd255, q_mb_reg};
            3'd2: result = '{q_mb_reg, 8'd255, q_xb_reg};
            3'd3: result = '{q_mb_reg, q_xb_reg, 8'd255};
            3'd4: result = '{q_xb_reg, q_mb_reg, 8'd255};
            default: result = '{8'd255, q_mb_reg, q_xb_reg};
        endcase
        if (white_reg) begin
            result = '{8'd255, 8'd255, 8'd255};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fvhsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// fvhsv_ctrl: sequencer of the flow color coder
// Steps root and angle together, then, for a color item, the division and the output slot.
// ----------------------------------------------------------------------------
`default_nettype none
module fvhsv_ctrl
    import fvhsv_pkg::*;
#(
    parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire fvhsv_sts_t sts,
    output fvhsv_cmd_t      cmd,
    output logic [5:0]      step
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int ROOT_STEPS = FLOW_WIDTH + 1;
    localparam int SEQ_STEPS = (ROOT_STEPS > CORDIC_STEPS) ? ROOT_STEPS : CORDIC_STEPS;
    localparam logic [5:0] ROOT_LAST = 6'(SEQ_STEPS - 1);
    localparam int NUM_STEPS = 36;

    logic [2:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       valid_reg, valid_next;

    assign step = step_reg;
    assign m_valid = valid_reg;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        valid_next = valid_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    step_next = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.sqrt_step = (step_reg < 6'(ROOT_STEPS));
                cmd.cordic_step = (step_reg < 6'(CORDIC_STEPS));
                step_next = step_reg + 6'd1;
                if (step_reg == ROOT_LAST) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (sts.is_color) begin
                    cmd.prep_div = 1'b1;
                    step_next = '0;
                    state_next = ST_DIV;
                end else begin
                    cmd.measure_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(NUM_STEPS - 1)) begin
                    valid_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            valid_reg <= valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/fvhsv_checker.sv =====
// ----------------------------------------------------------------------------
// fvhsv_checker: port-level checks of the flow color coder
// Watches the handshakes on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module fvhsv_checker
    import fvhsv_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire fvhsv_out_t m_data
);
    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    // Accept no item while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("item accepted with result pending");
    // No result right after acceptance
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind flow_vector_to_hsv_color_unit fvhsv_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
